### rtl/core/mgm_pkg.sv
// mgm_pkg: shared constants and types for the maxout group-max block.
// No dependencies; imported by every module under rtl/core.
package mgm_pkg;

    // Parameter defaults
    localparam int DEF_MAX_FEATURE = 4096;
    localparam int DEF_MAX_GROUP   = 16;
    localparam int DEF_DATA_WIDTH  = 16;

    // Fixed field widths
    localparam int OFF_W      = 16;  // argmax offset
    localparam int GRP_CFG_W  = 5;   // group_size register
    localparam int PIX_CFG_W  = 13;  // feature_size register
    localparam int CFG_DATA_W = 13;  // widest register
    localparam int CFG_IDX_W  = 2;

    // Output queue
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROUP_SIZE   = 2'd0,
        REG_FEATURE_SIZE = 2'd1
    } mgm_reg_t;

    // Per-beat control from the sequencer to the store
    typedef struct packed {
        logic first;  // first map of the group: load entry
        logic emit;   // last map of the group: produce a result
        logic eom;    // last pixel of the map
    } mgm_flags_t;

endpackage

### rtl/core/mgm_seq.sv
// mgm_seq: configuration registers, pixel/group counters and offset base.
// Depends on mgm_pkg.
module mgm_seq #(
    parameter int MAX_FEATURE = mgm_pkg::DEF_MAX_FEATURE,
    parameter int MAX_GROUP   = mgm_pkg::DEF_MAX_GROUP,
    localparam int PIX_W = (MAX_FEATURE > 1) ? $clog2(MAX_FEATURE) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mgm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    output logic [PIX_W-1:0]               pix_addr,
    output logic [mgm_pkg::OFF_W-1:0]      offset,
    output mgm_pkg::mgm_flags_t            flags
);
    import mgm_pkg::*;

    localparam int GRP_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic [GRP_W-1:0] grp_last_reg, grp_last_next;
    logic [PIX_W-1:0] pix_last_reg, pix_last_next;
    logic [OFF_W-1:0] pix_step_reg, pix_step_next;
    logic [PIX_W-1:0] p_reg, p_next;
    logic [GRP_W-1:0] g_reg, g_next;
    logic [OFF_W-1:0] base_reg, base_next;   // g * pixels

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_last_reg <= '0;
            pix_last_reg <= '0;
            pix_step_reg <= OFF_W'(1);
            p_reg        <= '0;
            g_reg        <= '0;
            base_reg     <= '0;
        end
        else
        begin
            grp_last_reg <= grp_last_next;
            pix_last_reg <= pix_last_next;
            pix_step_reg <= pix_step_next;
            p_reg        <= p_next;
            g_reg        <= g_next;
            base_reg     <= base_next;
        end
    end

    always_comb
    begin
        int grp_eff;
        int pix_eff;
        grp_eff = int'(cfg_data[GRP_CFG_W-1:0]);
        pix_eff = int'(cfg_data[PIX_CFG_W-1:0]);
        if (grp_eff == 0)
            grp_eff = 1;
        else if (grp_eff > MAX_GROUP)
            grp_eff = MAX_GROUP;
        if (pix_eff == 0)
            pix_eff = 1;
        else if (pix_eff > MAX_FEATURE)
            pix_eff = MAX_FEATURE;

        grp_last_next = grp_last_reg;
        pix_last_next = pix_last_reg;
        pix_step_next = pix_step_reg;
        p_next        = p_reg;
        g_next        = g_reg;
        base_next     = base_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_GROUP_SIZE:
                begin
                    grp_last_next = GRP_W'(grp_eff - 1);
                    p_next        = '0;
                    g_next        = '0;
                    base_next     = '0;
                end
                REG_FEATURE_SIZE:
                begin
                    pix_last_next = PIX_W'(pix_eff - 1);
                    pix_step_next = OFF_W'(pix_eff);
                    p_next        = '0;
                    g_next        = '0;
                    base_next     = '0;
                end
                default: ;
            endcase
        end
        else if (accept)
        begin
            if (p_reg == pix_last_reg)
            begin
                p_next = '0;
                if (g_reg == grp_last_reg)
                begin
                    g_next    = '0;
                    base_next = '0;
                end
                else
                begin
                    g_next    = g_reg + GRP_W'(1);
                    base_next = base_reg + pix_step_reg;
                end
            end
            else
            begin
                p_next = p_reg + PIX_W'(1);
            end
        end
    end

    assign pix_addr    = p_reg;
    assign offset      = base_reg + OFF_W'(p_reg);
    assign flags.first = (g_reg == '0);
    assign flags.emit  = (g_reg == grp_last_reg);
    assign flags.eom   = (p_reg == pix_last_reg);

    a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= pix_last_reg)
        else $error("pixel counter beyond map size");

    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        g_reg <= grp_last_reg)
        else $error("group counter beyond group size");

endmodule

### rtl/core/mgm_store.sv
// mgm_store: per-pixel running max/offset memory with compare and write-back.
// Depends on mgm_pkg.
module mgm_store #(
    parameter int MAX_FEATURE = mgm_pkg::DEF_MAX_FEATURE,
    parameter int DATA_WIDTH  = mgm_pkg::DEF_DATA_WIDTH,
    localparam int PIX_W = (MAX_FEATURE > 1) ? $clog2(MAX_FEATURE) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_acc,
    input  logic [PIX_W-1:0]              pix_addr,
    input  logic signed [DATA_WIDTH-1:0]  sample,
    input  logic [mgm_pkg::OFF_W-1:0]     offset,
    input  mgm_pkg::mgm_flags_t           flags,
    output logic                          s1_busy,
    output logic                          res_valid,
    output logic signed [DATA_WIDTH-1:0]  res_max,
    output logic [mgm_pkg::OFF_W-1:0]     res_offset,
    output logic                          res_eom
);
    import mgm_pkg::*;

    localparam int ENT_W = DATA_WIDTH + OFF_W;

    logic [ENT_W-1:0] mem [MAX_FEATURE];
    logic [ENT_W-1:0] rd_data_reg;

    logic                         s1_valid_reg;
    logic [PIX_W-1:0]             s1_addr_reg;
    logic signed [DATA_WIDTH-1:0] s1_sample_reg;
    logic [OFF_W-1:0]             s1_offset_reg;
    mgm_flags_t                   s1_flags_reg;

    // Write issued on the same edge as the read of this beat
    logic                         wl_valid_reg;
    logic [PIX_W-1:0]             wl_addr_reg;
    logic [ENT_W-1:0]             wl_data_reg;

    logic [ENT_W-1:0]             old_ent;
    logic signed [DATA_WIDTH-1:0] old_max;
    logic                         take;
    logic [ENT_W-1:0]             new_ent;

    always_ff @(posedge clk)
    begin
        if (in_acc)
            rd_data_reg <= mem[pix_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            mem[s1_addr_reg] <= new_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wl_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            wl_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_addr_reg   <= pix_addr;
            s1_sample_reg <= sample;
            s1_offset_reg <= offset;
            s1_flags_reg  <= flags;
        end
        wl_addr_reg <= s1_addr_reg;
        wl_data_reg <= new_ent;
    end

    // Forward the write that raced the read (feature size of one)
    assign old_ent = (wl_valid_reg && (wl_addr_reg == s1_addr_reg)) ? wl_data_reg
                                                                    : rd_data_reg;
    assign old_max = old_ent[ENT_W-1 -: DATA_WIDTH];
    // Strictly greater: earliest maximum wins
    assign take    = s1_flags_reg.first || (s1_sample_reg > old_max);
    assign new_ent = take ? {s1_sample_reg, s1_offset_reg} : old_ent;

    assign s1_busy    = s1_valid_reg;
    assign res_valid  = s1_valid_reg && s1_flags_reg.emit;
    assign res_max    = new_ent[ENT_W-1 -: DATA_WIDTH];
    assign res_offset = new_ent[OFF_W-1:0];
    assign res_eom    = s1_flags_reg.eom;

    a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.first |-> res_max == s1_sample_reg)
        else $error("first map did not load the sample");

    a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_flags_reg.first |-> res_max >= old_max)
        else $error("running max decreased");

endmodule

### rtl/core/mgm_out_fifo.sv
// mgm_out_fifo: small result queue decoupling the store from output stall.
// Depends on mgm_pkg.
module mgm_out_fifo #(
    parameter int WIDTH = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [WIDTH-1:0]              push_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [WIDTH-1:0]              out_data,
    output logic [mgm_pkg::OUT_CNT_W-1:0] count
);
    import mgm_pkg::*;

    logic [WIDTH-1:0]     slot [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pop;

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                : wr_ptr_reg + OUT_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                : rd_ptr_reg + OUT_PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + OUT_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - OUT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= push_data;
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot[rd_ptr_reg];
    assign count     = cnt_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> cnt_reg != OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

endmodule

### rtl/core/maxout_group_max.sv
// maxout_group_max: top level of the maxout group-max block.
// Depends on mgm_pkg, mgm_seq, mgm_store, mgm_out_fifo.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------
//  in      | in_valid  | in_stall  | sample
//  out     | out_valid | out_stall | max_value, argmax_offset, end_of_map
//  cfg     | cfg_we    | (none)    | cfg_index, cfg_data
//
// One sample beat per cycle while in_stall is low. A beat reads its pixel's
// entry on the accept edge, compares and writes back on the next edge; the
// result (last map of a group only) enters the result queue on that
// write-back edge and can be taken on the edge after.
// One read and one write on the store per cycle set the rate; back-to-back
// hits on one pixel are forwarded from the write-back register.
// rst_n clears counters and config (group_size = 1, feature_size = 1); the
// store is not cleared, since the first map of each group loads every pixel.
// in_stall rises only when the three-entry result queue plus the beat in
// flight could not absorb another result; it never looks at in_valid.
module maxout_group_max #(
    parameter int MAX_FEATURE = mgm_pkg::DEF_MAX_FEATURE,
    parameter int MAX_GROUP   = mgm_pkg::DEF_MAX_GROUP,
    parameter int DATA_WIDTH  = mgm_pkg::DEF_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mgm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [DATA_WIDTH-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [DATA_WIDTH-1:0]   max_value,
    output logic [mgm_pkg::OFF_W-1:0]      argmax_offset,
    output logic                           end_of_map
);
    import mgm_pkg::*;

    localparam int PIX_W = (MAX_FEATURE > 1) ? $clog2(MAX_FEATURE) : 1;
    localparam int RES_W = DATA_WIDTH + OFF_W + 1;

    logic                         accept;
    logic [PIX_W-1:0]             pix_addr;
    logic [OFF_W-1:0]             offset;
    mgm_flags_t                   flags;

    logic                         s1_busy;
    logic                         res_valid;
    logic signed [DATA_WIDTH-1:0] res_max;
    logic [OFF_W-1:0]             res_offset;
    logic                         res_eom;

    logic [RES_W-1:0]             q_data;
    logic [OUT_CNT_W-1:0]         q_count;
    logic [OUT_CNT_W:0]           q_load;

    // Queue entries taken plus the beat still in the compare stage
    assign q_load   = {1'b0, q_count} + (OUT_CNT_W + 1)'(s1_busy);
    assign in_stall = (q_load >= (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign accept   = in_valid && !in_stall;

    mgm_seq #(
        .MAX_FEATURE (MAX_FEATURE),
        .MAX_GROUP   (MAX_GROUP)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pix_addr  (pix_addr),
        .offset    (offset),
        .flags     (flags)
    );

    mgm_store #(
        .MAX_FEATURE (MAX_FEATURE),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_acc     (accept),
        .pix_addr   (pix_addr),
        .sample     (sample),
        .offset     (offset),
        .flags      (flags),
        .s1_busy    (s1_busy),
        .res_valid  (res_valid),
        .res_max    (res_max),
        .res_offset (res_offset),
        .res_eom    (res_eom)
    );

    mgm_out_fifo #(
        .WIDTH (RES_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data ({res_max, res_offset, res_eom}),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign max_value     = q_data[RES_W-1 -: DATA_WIDTH];
    assign argmax_offset = q_data[OFF_W:1];
    assign end_of_map    = q_data[0];

    a_stall_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> q_count != OUT_CNT_W'(OUT_DEPTH))
        else $error("beat accepted without room for its result");

endmodule
